/* sv/cpc_pkg.sv */
// Shared constants, codes and types of the convex polygon point classifier.
package cpc_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = VIDX_W + 1;
	localparam int VC_W         = 7;
	localparam int COORD_W      = 16;
	localparam int EPS_W        = 16;
	localparam int LOC_W        = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int CROSS_W      = PROD_W + 1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [LOC_W-1:0] LOC_INSIDE  = LOC_W'(0);
	localparam logic [LOC_W-1:0] LOC_OUTSIDE = LOC_W'(1);
	localparam logic [LOC_W-1:0] LOC_EDGE    = LOC_W'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_EPSILON = CFG_IDX_W'(1);

	localparam logic [VC_W-1:0]  VC_RST  = VC_W'(3);
	localparam logic [VC_W-1:0]  VC_MIN  = VC_W'(3);
	localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);

	typedef struct packed {
		logic                      valid;
		logic                      req_type;
		logic [VIDX_W-1:0]         vidx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] v0x;
		logic signed [COORD_W-1:0] v0y;
		logic                      done;
		logic [LOC_W-1:0]          loc;
		logic [VIDX_W-1:0]         edge_idx;
	} tok_t;

	typedef struct packed {
		logic [CNT_W-1:0] n_eff;
		logic [EPS_W-1:0] eps;
	} cfg_t;

endpackage

/* sv/cpc_if.sv */
// Channel interfaces: request, response and configuration write.
interface cpc_req_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [cpc_pkg::VIDX_W-1:0]         vertex_index;
	logic signed [cpc_pkg::COORD_W-1:0] coord_x;
	logic signed [cpc_pkg::COORD_W-1:0] coord_y;

	modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
	modport sink (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

interface cpc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cpc_pkg::LOC_W-1:0]   location;
	logic [cpc_pkg::VIDX_W-1:0]  deciding_edge;

	modport source (output valid, location, deciding_edge, input ready);
	modport sink (input valid, location, deciding_edge, output ready);
endinterface

interface cpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cpc_pkg::CFG_IDX_W-1:0]  index;
	logic [cpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/cpc_cfg.sv */
// Configuration registers with vertex count clamping.
module cpc_cfg (
	input  logic          clk,
	input  logic          arst_n,
	cpc_cfg_if.sink       cfg,
	output cpc_pkg::cfg_t cfg_o
);

	logic [cpc_pkg::VC_W-1:0]  vc_q;
	logic [cpc_pkg::EPS_W-1:0] eps_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q  <= cpc_pkg::VC_RST;
			eps_q <= cpc_pkg::EPS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cpc_pkg::CFG_VERTEX_COUNT: vc_q  <= cfg.data[cpc_pkg::VC_W-1:0];
				cpc_pkg::CFG_EDGE_EPSILON: eps_q <= cfg.data[cpc_pkg::EPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(vc_q) > cpc_pkg::MAX_VERTICES) begin
			cfg_o.n_eff = cpc_pkg::CNT_W'(cpc_pkg::MAX_VERTICES);
		end else if (vc_q < cpc_pkg::VC_MIN) begin
			cfg_o.n_eff = cpc_pkg::CNT_W'(cpc_pkg::VC_MIN);
		end else begin
			cfg_o.n_eff = cpc_pkg::CNT_W'(vc_q);
		end
		cfg_o.eps = eps_q;
	end

endmodule

/* sv/cpc_cell.sv */
// One edge cell: holds a vertex and its successor, tests one hull edge in two stages.
module cpc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  cpc_pkg::cfg_t               cfg,
	input  logic [cpc_pkg::CNT_W-1:0]   idx,
	input  cpc_pkg::tok_t               tok_in,
	output cpc_pkg::tok_t               tok_out
);

	logic signed [cpc_pkg::COORD_W-1:0] vx_q, vy_q, nx_q, ny_q;
	logic signed [cpc_pkg::COORD_W-1:0] v0x, v0y, ex_end, ey_end;
	logic signed [cpc_pkg::DIFF_W-1:0]  dx, dy, ex, ey;
	logic signed [cpc_pkg::PROD_W-1:0]  p1_s1, p2_s1;
	logic signed [cpc_pkg::CROSS_W-1:0] xprod;
	logic [cpc_pkg::CROSS_W-1:0]        mag;
	logic                               is_load, wrap, act, act_s1;
	cpc_pkg::tok_t                      tok_a, tok_s1, tok_b, tok_s2;

	assign is_load = tok_in.valid && (tok_in.req_type == cpc_pkg::REQ_LOAD);

	always_ff @(posedge clk) begin
		if (adv && is_load) begin
			if (cpc_pkg::CNT_W'(tok_in.vidx) == idx) begin
				vx_q <= tok_in.x;
				vy_q <= tok_in.y;
			end
			if (cpc_pkg::CNT_W'(tok_in.vidx) == idx + cpc_pkg::CNT_W'(1)) begin
				nx_q <= tok_in.x;
				ny_q <= tok_in.y;
			end
		end
	end

	always_comb begin
		v0x    = (idx == '0) ? vx_q : tok_in.v0x;
		v0y    = (idx == '0) ? vy_q : tok_in.v0y;
		wrap   = (idx + cpc_pkg::CNT_W'(1)) == cfg.n_eff;
		act    = idx < cfg.n_eff;
		ex_end = wrap ? v0x : nx_q;
		ey_end = wrap ? v0y : ny_q;
		dx     = cpc_pkg::DIFF_W'(tok_in.x) - cpc_pkg::DIFF_W'(vx_q);
		dy     = cpc_pkg::DIFF_W'(tok_in.y) - cpc_pkg::DIFF_W'(vy_q);
		ex     = cpc_pkg::DIFF_W'(ex_end) - cpc_pkg::DIFF_W'(vx_q);
		ey     = cpc_pkg::DIFF_W'(ey_end) - cpc_pkg::DIFF_W'(vy_q);
		tok_a     = tok_in;
		tok_a.v0x = v0x;
		tok_a.v0y = v0y;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1  <= cpc_pkg::PROD_W'(dx) * cpc_pkg::PROD_W'(ey);
			p2_s1  <= cpc_pkg::PROD_W'(dy) * cpc_pkg::PROD_W'(ex);
			act_s1 <= act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_a;
			tok_s2 <= tok_b;
		end
	end

	always_comb begin
		xprod = cpc_pkg::CROSS_W'(p1_s1) - cpc_pkg::CROSS_W'(p2_s1);
		mag   = xprod[cpc_pkg::CROSS_W-1] ? cpc_pkg::CROSS_W'(-xprod)
		                                  : cpc_pkg::CROSS_W'(xprod);
		tok_b = tok_s1;
		if (tok_s1.valid && tok_s1.req_type == cpc_pkg::REQ_QUERY && !tok_s1.done && act_s1) begin
			if (mag < cpc_pkg::CROSS_W'(cfg.eps)) begin
				tok_b.done     = 1'b1;
				tok_b.loc      = cpc_pkg::LOC_EDGE;
				tok_b.edge_idx = idx[cpc_pkg::VIDX_W-1:0];
			end else if (xprod[cpc_pkg::CROSS_W-1]) begin
				tok_b.done     = 1'b1;
				tok_b.loc      = cpc_pkg::LOC_OUTSIDE;
				tok_b.edge_idx = idx[cpc_pkg::VIDX_W-1:0];
			end
		end
	end

	assign tok_out = tok_s2;

endmodule

/* sv/convex_polygon_point_classifier.sv */
// Top level: point classification against a convex hull on a chain of edge cells.
//
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    req_type, vertex_index, coord_x, coord_y
//  rsp      out  rsp.valid/ready    location, deciding_edge
//  cfg      in   cfg.valid/ready    index, data (0 vertex_count, 1 edge_epsilon)
//
// One transaction enters per cycle unless rsp stalls; each one walks all cells in
// order, and a query result is registered onto rsp after the last cell.
// Loads travel the same chain and write their cell in order with the queries.
// A stalled rsp freezes the whole chain and drops req.ready.
// Reset clears the chain and resets the config; the hull holds nothing until loaded.
module convex_polygon_point_classifier (
	input  logic      clk,
	input  logic      arst_n,
	cpc_req_if.sink   req,
	cpc_rsp_if.source rsp,
	cpc_cfg_if.sink   cfg
);

	cpc_pkg::cfg_t                cfg_n;
	cpc_pkg::tok_t                chain [0:cpc_pkg::MAX_VERTICES];
	logic                         adv;
	logic                         rsp_valid_q;
	logic [cpc_pkg::LOC_W-1:0]    loc_q;
	logic [cpc_pkg::VIDX_W-1:0]   edge_q;

	cpc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_n)
	);

	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = adv;

	always_comb begin
		chain[0]          = '0;
		chain[0].valid    = req.valid;
		chain[0].req_type = req.req_type;
		chain[0].vidx     = req.vertex_index;
		chain[0].x        = req.coord_x;
		chain[0].y        = req.coord_y;
		chain[0].loc      = cpc_pkg::LOC_INSIDE;
	end

	for (genvar g = 0; g < cpc_pkg::MAX_VERTICES; g++) begin : g_cell
		cpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.cfg     (cfg_n),
			.idx     (cpc_pkg::CNT_W'(g)),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= chain[cpc_pkg::MAX_VERTICES].valid &&
			               (chain[cpc_pkg::MAX_VERTICES].req_type == cpc_pkg::REQ_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			loc_q  <= chain[cpc_pkg::MAX_VERTICES].loc;
			edge_q <= chain[cpc_pkg::MAX_VERTICES].edge_idx;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.location      = loc_q;
	assign rsp.deciding_edge = edge_q;

	a_loc_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.location == cpc_pkg::LOC_INSIDE ||
		               rsp.location == cpc_pkg::LOC_OUTSIDE ||
		               rsp.location == cpc_pkg::LOC_EDGE))
		else $error("invalid location code");

	a_inside_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.location == cpc_pkg::LOC_INSIDE) |-> (rsp.deciding_edge == '0))
		else $error("inside result with nonzero edge");

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (cpc_pkg::CNT_W'(rsp.deciding_edge) < cfg_n.n_eff))
		else $error("deciding edge beyond vertex count");

	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain[cpc_pkg::MAX_VERTICES]))
		else $error("chain moved while stalled");

endmodule
